// File: hw/rtl/mbmc_pkg.sv
// Shared constants and types for the motion box merge and classify block.
package mbmc_pkg;

	// Default sizes for the top-level parameters.
	localparam int DEF_TABLE_DEPTH = 32;
	localparam int DEF_COORD_BITS  = 12;

	// Fixed field widths.
	localparam int AREA_BITS    = 25;
	localparam int MAXAREA_BITS = 24;
	localparam int WR_IDX_BITS  = 3;

	// Depth of the queue between the front and back parts.
	localparam int FQ_PTR_W = 2;
	localparam int FQ_DEPTH = 1 << FQ_PTR_W;

	// Register indexes on the configuration port.
	localparam logic [WR_IDX_BITS-1:0] REG_MIN_AREA = 3'd0;
	localparam logic [WR_IDX_BITS-1:0] REG_MAX_AREA = 3'd1;
	localparam logic [WR_IDX_BITS-1:0] REG_ROI_X    = 3'd2;
	localparam logic [WR_IDX_BITS-1:0] REG_ROI_Y    = 3'd3;
	localparam logic [WR_IDX_BITS-1:0] REG_ROI_W    = 3'd4;
	localparam logic [WR_IDX_BITS-1:0] REG_ROI_H    = 3'd5;

	// Reset values of the registers.
	localparam logic [AREA_BITS-1:0]    RST_MIN_AREA = 25'd1600;
	localparam logic [MAXAREA_BITS-1:0] RST_MAX_AREA = 24'd368640;

	// Region classes.
	localparam logic [1:0] CLASS_INSIDE  = 2'd0;
	localparam logic [1:0] CLASS_OVERLAY = 2'd1;
	localparam logic [1:0] CLASS_OUTSIDE = 2'd2;

	// Control bits that travel with each queued box.
	typedef struct packed {
		logic keep;
		logic fend;
	} ctl_t;

endpackage

// File: hw/rtl/mbmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/mbmc_front.sv
// Front part: accepts blob requests, marks each with the area filter result and queues them.
module mbmc_front #(
	parameter int COORD_BITS = mbmc_pkg::DEF_COORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [COORD_BITS-1:0]          box_x,
	input  logic [COORD_BITS-1:0]          box_y,
	input  logic [COORD_BITS-1:0]          box_w,
	input  logic [COORD_BITS-1:0]          box_h,
	input  logic [mbmc_pkg::AREA_BITS-1:0] blob_area_x2,
	input  logic                           frame_end,
	input  logic [mbmc_pkg::AREA_BITS-1:0] min_area_x2,
	output logic                           q_valid,
	input  logic                           q_pop,
	output logic [4*(COORD_BITS+1)-1:0]    q_box,
	output mbmc_pkg::ctl_t                 q_ctl
);

	localparam int CW    = COORD_BITS + 1;
	localparam int BOX_W = 4 * CW;

	logic [BOX_W-1:0]           box_mem_q [mbmc_pkg::FQ_DEPTH];
	mbmc_pkg::ctl_t             ctl_mem_q [mbmc_pkg::FQ_DEPTH];
	logic [mbmc_pkg::FQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [mbmc_pkg::FQ_PTR_W:0]   fill_q;
	logic                       acc;
	logic [BOX_W-1:0]           new_box;
	mbmc_pkg::ctl_t             new_ctl;

	assign full    = (fill_q == (mbmc_pkg::FQ_PTR_W+1)'(mbmc_pkg::FQ_DEPTH));
	assign acc     = push && !full;
	assign q_valid = (fill_q != '0);
	assign q_box   = box_mem_q[rd_ptr_q];
	assign q_ctl   = ctl_mem_q[rd_ptr_q];

	// Convert to corner form and decide whether the blob is large enough.
	always_comb begin
		new_box = {({1'b0, box_y} + {1'b0, box_h}), ({1'b0, box_x} + {1'b0, box_w}),
			{1'b0, box_y}, {1'b0, box_x}};
		new_ctl.keep = (blob_area_x2 > min_area_x2);
		new_ctl.fend = frame_end;
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (acc) begin
			box_mem_q[wr_ptr_q] <= new_box;
			ctl_mem_q[wr_ptr_q] <= new_ctl;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (acc && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!acc && q_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/mbmc_back.sv
// Back part: box table, merge passes, area filter, region class and result register.
module mbmc_back #(
	parameter int TABLE_DEPTH = mbmc_pkg::DEF_TABLE_DEPTH,
	parameter int COORD_BITS  = mbmc_pkg::DEF_COORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  logic [4*(COORD_BITS+1)-1:0]       q_box,
	input  mbmc_pkg::ctl_t                    q_ctl,
	input  logic [mbmc_pkg::MAXAREA_BITS-1:0] area_lim,
	input  logic [COORD_BITS-1:0]             roi_x,
	input  logic [COORD_BITS-1:0]             roi_y,
	input  logic [COORD_BITS-1:0]             roi_w,
	input  logic [COORD_BITS-1:0]             roi_h,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        region_class,
	output logic [COORD_BITS-1:0]             out_x,
	output logic [COORD_BITS-1:0]             out_y,
	output logic [COORD_BITS-1:0]             out_w,
	output logic [COORD_BITS-1:0]             out_h,
	output logic                              box_valid,
	output logic                              table_overflow,
	output logic                              last
);

	localparam int CW     = COORD_BITS + 1;
	localparam int BOX_W  = 4 * CW;
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int PROD_W = 2 * CW;
	localparam int CMP_W  = (PROD_W > mbmc_pkg::MAXAREA_BITS) ? PROD_W : mbmc_pkg::MAXAREA_BITS;

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_ISEEK = 4'd1;
	localparam logic [3:0] S_ILOAD = 4'd2;
	localparam logic [3:0] S_JSEEK = 4'd3;
	localparam logic [3:0] S_JTEST = 4'd4;
	localparam logic [3:0] S_OSEEK = 4'd5;
	localparam logic [3:0] S_OAREA = 4'd6;
	localparam logic [3:0] S_OEVAL = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]             state_q;
	logic [CNT_W-1:0]       cnt_q, i_q, j_q;
	logic                   ovf_q, skip_q, found_q;
	logic [TABLE_DEPTH-1:0] alive_q;
	logic [BOX_W-1:0]       cur_q, box_s1, pend_q;
	logic [PROD_W-1:0]      prod_s1;
	logic [1:0]             pend_cls_q;
	logic                   pend_v_q;

	logic                   out_v_q, out_bv_q, out_ovf_q, out_last_q;
	logic [1:0]             out_cls_q;
	logic [COORD_BITS-1:0]  out_x_q, out_y_q, out_w_q, out_h_q;

	// RAM port signals.
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [BOX_W-1:0] ram_wdata, ram_rdata;

	mbmc_ram #(
		.WIDTH(BOX_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Overlap test between the running union and the candidate box.
	logic [CW-1:0] cl, ct, cr, cb, rl, rt, rr, rb;
	logic          overlap;
	logic [BOX_W-1:0] union_box;
	always_comb begin
		cl = cur_q[CW-1:0];
		ct = cur_q[2*CW-1:CW];
		cr = cur_q[3*CW-1:2*CW];
		cb = cur_q[4*CW-1:3*CW];
		rl = ram_rdata[CW-1:0];
		rt = ram_rdata[2*CW-1:CW];
		rr = ram_rdata[3*CW-1:2*CW];
		rb = ram_rdata[4*CW-1:3*CW];
		overlap = ((cr < rr ? cr : rr) > (cl > rl ? cl : rl)) &&
			((cb < rb ? cb : rb) > (ct > rt ? ct : rt));
		union_box = {(cb > rb ? cb : rb), (cr > rr ? cr : rr),
			(ct < rt ? ct : rt), (cl < rl ? cl : rl)};
	end

	// Width and height of the box just read, for the area product.
	logic [CW-1:0] aw, ah;
	always_comb begin
		aw = (rr > rl) ? (rr - rl) : '0;
		ah = (rb > rt) ? (rb - rt) : '0;
	end

	// Region class of the registered box against the region of interest.
	logic [CW-1:0] bl, bt, br, bb, gl, gt, gr, gb, il, it, ir, ib;
	logic [1:0]    eval_cls;
	logic          reportable;
	always_comb begin
		bl = box_s1[CW-1:0];
		bt = box_s1[2*CW-1:CW];
		br = box_s1[3*CW-1:2*CW];
		bb = box_s1[4*CW-1:3*CW];
		gl = {1'b0, roi_x};
		gt = {1'b0, roi_y};
		gr = {1'b0, roi_x} + {1'b0, roi_w};
		gb = {1'b0, roi_y} + {1'b0, roi_h};
		il = (bl > gl) ? bl : gl;
		it = (bt > gt) ? bt : gt;
		ir = (br < gr) ? br : gr;
		ib = (bb < gb) ? bb : gb;
		if (!(ir > il) || !(ib > it)) begin
			eval_cls = mbmc_pkg::CLASS_OUTSIDE;
		end else if (il == bl && ir == br && it == bt && ib == bb) begin
			eval_cls = mbmc_pkg::CLASS_INSIDE;
		end else begin
			eval_cls = mbmc_pkg::CLASS_OVERLAY;
		end
		reportable = (CMP_W'(prod_s1) <= CMP_W'(area_lim));
	end

	// Result register handshake and what goes into it.
	logic             out_free, emit, emit_bv, emit_last;
	logic [BOX_W-1:0] emit_box;
	logic [1:0]       emit_cls;
	assign out_free = !out_v_q || pop;

	always_comb begin
		emit      = 1'b0;
		emit_bv   = pend_v_q;
		emit_last = 1'b0;
		emit_box  = pend_q;
		emit_cls  = pend_cls_q;
		if (state_q == S_OEVAL && reportable && pend_v_q && out_free) begin
			emit = 1'b1;
		end
		if (state_q == S_DONE && out_free) begin
			emit      = 1'b1;
			emit_last = 1'b1;
			if (!pend_v_q) begin
				emit_box = '0;
				emit_cls = mbmc_pkg::CLASS_INSIDE;
			end
		end
	end

	// Table access for each state.
	always_comb begin
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IDX_W-1:0];
		ram_wdata = q_box;
		ram_re    = 1'b0;
		ram_raddr = i_q[IDX_W-1:0];
		case (state_q)
			S_LOAD: begin
				q_pop  = q_valid;
				ram_we = q_valid && q_ctl.keep && (cnt_q < CNT_W'(TABLE_DEPTH));
			end
			S_ISEEK, S_OSEEK: begin
				ram_re = (i_q < cnt_q) && alive_q[i_q[IDX_W-1:0]];
			end
			S_JSEEK: begin
				ram_raddr = j_q[IDX_W-1:0];
				if (j_q >= cnt_q) begin
					ram_we    = 1'b1;
					ram_waddr = i_q[IDX_W-1:0];
					ram_wdata = cur_q;
				end else begin
					ram_re = alive_q[j_q[IDX_W-1:0]] && !skip_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer for loading, merge passes and result selection.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			alive_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			skip_q   <= 1'b0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (q_valid) begin
						if (q_ctl.keep) begin
							if (cnt_q < CNT_W'(TABLE_DEPTH)) begin
								alive_q[cnt_q[IDX_W-1:0]] <= 1'b1;
								cnt_q <= cnt_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (q_ctl.fend) begin
							i_q     <= '0;
							found_q <= 1'b0;
							state_q <= S_ISEEK;
						end
					end
				end
				S_ISEEK: begin
					if (i_q >= cnt_q) begin
						i_q     <= '0;
						found_q <= 1'b0;
						if (!found_q) begin
							pend_v_q <= 1'b0;
							state_q  <= S_OSEEK;
						end
					end else if (!alive_q[i_q[IDX_W-1:0]]) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_ILOAD;
					end
				end
				S_ILOAD: begin
					j_q     <= i_q + 1'b1;
					skip_q  <= 1'b0;
					state_q <= S_JSEEK;
				end
				S_JSEEK: begin
					if (j_q >= cnt_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ISEEK;
					end else if (!alive_q[j_q[IDX_W-1:0]]) begin
						j_q <= j_q + 1'b1;
					end else if (skip_q) begin
						// The entry after a removal is passed over.
						skip_q <= 1'b0;
						j_q    <= j_q + 1'b1;
					end else begin
						state_q <= S_JTEST;
					end
				end
				S_JTEST: begin
					if (overlap) begin
						alive_q[j_q[IDX_W-1:0]] <= 1'b0;
						found_q <= 1'b1;
						skip_q  <= 1'b1;
					end
					j_q     <= j_q + 1'b1;
					state_q <= S_JSEEK;
				end
				S_OSEEK: begin
					if (i_q >= cnt_q) begin
						state_q <= S_DONE;
					end else if (!alive_q[i_q[IDX_W-1:0]]) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_OAREA;
					end
				end
				S_OAREA: begin
					state_q <= S_OEVAL;
				end
				S_OEVAL: begin
					if (!reportable) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_OSEEK;
					end else if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b1;
						i_q      <= i_q + 1'b1;
						state_q  <= S_OSEEK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						cnt_q    <= '0;
						ovf_q    <= 1'b0;
						alive_q  <= '0;
						pend_v_q <= 1'b0;
						state_q  <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Running union, area product and pending result.
	always_ff @(posedge clk) begin
		if (state_q == S_ILOAD) begin
			cur_q <= ram_rdata;
		end else if (state_q == S_JTEST && overlap) begin
			cur_q <= union_box;
		end
		if (state_q == S_OAREA) begin
			box_s1  <= ram_rdata;
			prod_s1 <= aw * ah;
		end
		if (state_q == S_OEVAL && reportable && (!pend_v_q || out_free)) begin
			pend_q     <= box_s1;
			pend_cls_q <= eval_cls;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// Result register payload; widths saturate at the coordinate range.
	logic [CW-1:0] ew, eh;
	always_comb begin
		ew = emit_box[3*CW-1:2*CW] - emit_box[CW-1:0];
		eh = emit_box[4*CW-1:3*CW] - emit_box[2*CW-1:CW];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_cls_q  <= emit_cls;
			out_x_q    <= emit_box[COORD_BITS-1:0];
			out_y_q    <= emit_box[CW+COORD_BITS-1:CW];
			out_w_q    <= ew[CW-1] ? '1 : ew[COORD_BITS-1:0];
			out_h_q    <= eh[CW-1] ? '1 : eh[COORD_BITS-1:0];
			out_bv_q   <= emit_bv;
			out_ovf_q  <= ovf_q;
			out_last_q <= emit_last;
		end
	end

	assign empty          = !out_v_q;
	assign region_class   = out_cls_q;
	assign out_x          = out_x_q;
	assign out_y          = out_y_q;
	assign out_w          = out_w_q;
	assign out_h          = out_h_q;
	assign box_valid      = out_bv_q;
	assign table_overflow = out_ovf_q;
	assign last           = out_last_q;

endmodule

// File: hw/rtl/motion_box_merge_classify.sv
// Top level of the motion box merge and classify block.
//
// Blob requests enter through push/full, one per cycle while the queue is not
// full, and are marked by the area filter in a four-entry queue. The back part
// loads each kept box into a table. After the request marked frame_end,
// overlapping boxes are merged pass by pass until a pass merges nothing; each
// pass reads the table through its single read port. Results are then selected
// and come out through empty/pop in table order, the final one marked last.
// A frame that reports nothing gives one result with box_valid low.
// The user must write registers through wr_en/wr_index/wr_data only while the
// block is idle; the block itself does not enforce this. Reset clears the queue,
// table count, overflow flag and result valid flag. When the receiver holds off
// pop, result selection waits for the result slot and the front queue keeps
// taking requests until it is full.
module motion_box_merge_classify #(
	parameter int TABLE_DEPTH = mbmc_pkg::DEF_TABLE_DEPTH,
	parameter int COORD_BITS  = mbmc_pkg::DEF_COORD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [mbmc_pkg::WR_IDX_BITS-1:0] wr_index,
	input  logic [mbmc_pkg::AREA_BITS-1:0]   wr_data,
	input  logic                             push,
	output logic                             full,
	input  logic [COORD_BITS-1:0]            box_x,
	input  logic [COORD_BITS-1:0]            box_y,
	input  logic [COORD_BITS-1:0]            box_w,
	input  logic [COORD_BITS-1:0]            box_h,
	input  logic [mbmc_pkg::AREA_BITS-1:0]   blob_area_x2,
	input  logic                             frame_end,
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       region_class,
	output logic [COORD_BITS-1:0]            out_x,
	output logic [COORD_BITS-1:0]            out_y,
	output logic [COORD_BITS-1:0]            out_w,
	output logic [COORD_BITS-1:0]            out_h,
	output logic                             box_valid,
	output logic                             table_overflow,
	output logic                             last
);

	logic [mbmc_pkg::AREA_BITS-1:0]    min_area_q;
	logic [mbmc_pkg::MAXAREA_BITS-1:0] area_lim_q;
	logic [COORD_BITS-1:0]             roi_x_q, roi_y_q, roi_w_q, roi_h_q;

	logic                        q_valid, q_pop;
	logic [4*(COORD_BITS+1)-1:0] q_box;
	mbmc_pkg::ctl_t              q_ctl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_area_q <= mbmc_pkg::RST_MIN_AREA;
			area_lim_q <= mbmc_pkg::RST_MAX_AREA;
			roi_x_q    <= '0;
			roi_y_q    <= '0;
			roi_w_q    <= '0;
			roi_h_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				mbmc_pkg::REG_MIN_AREA: min_area_q <= wr_data;
				mbmc_pkg::REG_MAX_AREA: area_lim_q <= wr_data[mbmc_pkg::MAXAREA_BITS-1:0];
				mbmc_pkg::REG_ROI_X:    roi_x_q    <= wr_data[COORD_BITS-1:0];
				mbmc_pkg::REG_ROI_Y:    roi_y_q    <= wr_data[COORD_BITS-1:0];
				mbmc_pkg::REG_ROI_W:    roi_w_q    <= wr_data[COORD_BITS-1:0];
				mbmc_pkg::REG_ROI_H:    roi_h_q    <= wr_data[COORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	mbmc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.box_x       (box_x),
		.box_y       (box_y),
		.box_w       (box_w),
		.box_h       (box_h),
		.blob_area_x2(blob_area_x2),
		.frame_end   (frame_end),
		.min_area_x2 (min_area_q),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_box       (q_box),
		.q_ctl       (q_ctl)
	);

	mbmc_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_box         (q_box),
		.q_ctl         (q_ctl),
		.area_lim      (area_lim_q),
		.roi_x         (roi_x_q),
		.roi_y         (roi_y_q),
		.roi_w         (roi_w_q),
		.roi_h         (roi_h_q),
		.empty         (empty),
		.pop           (pop),
		.region_class  (region_class),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_w         (out_w),
		.out_h         (out_h),
		.box_valid     (box_valid),
		.table_overflow(table_overflow),
		.last          (last)
	);

`ifndef SYNTHESIS
	// The back part never takes from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue popped while empty");

	// A result without a box is always the last of its frame.
	a_empty_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !box_valid) |-> last) else $error("empty result not last");

	// A result without a box carries a zero box.
	a_empty_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !box_valid) |-> (out_w == '0 && out_h == '0 && out_x == '0))
		else $error("empty result carries a box");
`endif

endmodule
